// ===== rtl/core/scba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg
// Shared widths, codes and control types of the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   // Byte offsets and sizes.
   localparam int ADDR_W     = 20;          // payload offset width
   localparam int LEN_W      = 21;          // byte count width, holds 1 MiB
   localparam int SLOT_W     = 16;          // index of a 16-byte slot
   localparam int HDR_W      = 17;          // header and link entry width
   localparam int SLOTS_W    = 18;          // rounded payload in slots
   localparam int ROUND_W    = 22;          // rounded payload in bytes
   localparam int NEED_W     = 23;          // payload plus header in bytes
   localparam int SLOT_SHIFT = 4;
   localparam int SLOT_BYTES = 16;
   localparam int HEAD_SLOTS = 64;          // most classes the head store serves
   localparam int ADDR_CAP   = 1 << 20;     // bytes addressable by an offset
   localparam int NUM_SLOTS  = 1 << 16;     // depth of header and link stores

   // Request command codes.
   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STS_OK   = 2'd0,
      STS_OOM  = 2'd1,
      STS_ZERO = 2'd2,
      STS_LEAK = 2'd3
   } status_code_type;

   // Step commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // capture the request word
      logic look;      // decode, first store reads
      logic fetch;     // second store reads
      logic commit;    // store writes and result load
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic out_free;  // the result register can take a word this cycle
   } dp_status_type;

endpackage

// ===== rtl/core/scba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer that walks one request through decode, store reads and commit.
// ----------------------------------------------------------------------------
module scba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  scba_pkg::dp_status_type sts,
   output scba_pkg::dp_cmd_type    ctl
);
   import scba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOK   = 4'b0010,
      S_FETCH  = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: commit waits until the result register is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath.
   assign ctl.accept = (state_ff == S_IDLE) && req_valid;
   assign ctl.look   = (state_ff == S_LOOK);
   assign ctl.fetch  = (state_ff == S_FETCH);
   assign ctl.commit = (state_ff == S_COMMIT) && sts.out_free;

   assign req_stall = (state_ff != S_IDLE);

   // An accepted word always starts the decode step.
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> (state_ff == S_LOOK))
      else $error("accepted word did not move to decode");

   // A blocked commit holds its place until the result register drains.
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_COMMIT) && !sts.out_free) |=> (state_ff == S_COMMIT))
      else $error("commit left before the result register was free");

endmodule

// ===== rtl/core/scba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_datapath
// Request registers, bump and page pointers, class head, header and link
// stores, and the result register.
// ----------------------------------------------------------------------------
module scba_datapath #(
   parameter int NUM_CLASSES  = 64,
   parameter int HEAP_BYTES   = 1048576,
   parameter int REFILL_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scba_pkg::dp_cmd_type               ctl,
   output scba_pkg::dp_status_type            sts,
   input  logic                              req_command,
   input  logic [scba_pkg::LEN_W-1:0]        req_request_bytes,
   input  logic [scba_pkg::ADDR_W-1:0]       req_block_offset,
   input  logic                              csr_write_enable,
   input  logic [scba_pkg::LEN_W-1:0]        csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scba_pkg::ADDR_W-1:0]       rsp_payload_offset,
   output logic [1:0]                        rsp_status
);
   import scba_pkg::*;

   localparam int NCLS_EFF   = (NUM_CLASSES < HEAD_SLOTS) ? NUM_CLASSES : HEAD_SLOTS;
   localparam int CLS_W      = (NCLS_EFF > 1) ? $clog2(NCLS_EFF) : 1;
   localparam int HEAD_DEPTH = 1 << CLS_W;
   localparam int CAP_BYTES  = (HEAP_BYTES < ADDR_CAP) ? HEAP_BYTES : ADDR_CAP;

   localparam logic [LEN_W-1:0]   LIMIT_CAP = LEN_W'(CAP_BYTES);
   localparam logic [LEN_W-1:0]   REFILL    = LEN_W'(REFILL_BYTES);
   localparam logic [SLOTS_W-1:0] NCLS_SLOTS = SLOTS_W'(NCLS_EFF);
   localparam logic [HDR_W-1:0]   NCLS_HDR  = HDR_W'(NCLS_EFF);

   // Configuration: the effective heap limit is kept already clipped.
   logic [LEN_W-1:0] heap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= LIMIT_CAP;
      end else if (csr_write_enable) begin
         heap_limit_ff <= (csr_write_data > LIMIT_CAP) ? LIMIT_CAP : csr_write_data;
      end
   end

   // Request word register.
   logic               cmd_ff;
   logic [LEN_W-1:0]   req_bytes_ff;
   logic [ADDR_W-1:0]  offset_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff       <= req_command;
         req_bytes_ff <= req_request_bytes;
         offset_ff    <= req_block_offset;
      end
   end

   // Pointer registers.
   logic [LEN_W-1:0] bump_next_ff, bump_next_in;
   logic [LEN_W-1:0] bump_limit_ff, bump_limit_in;
   logic [LEN_W-1:0] map_next_ff, map_next_in;

   // Decode of the allocate size and the bump and page checks.
   logic [LEN_W-1:0]   req_adj;
   logic [ROUND_W-1:0] round_sum;
   logic [SLOTS_W-1:0] slots_a;
   logic [NEED_W-1:0]  need_a;
   logic [LEN_W-1:0]   bump_gap;
   logic [LEN_W-1:0]   map_gap;
   logic               pooled_a;
   logic [CLS_W-1:0]   cls_a;
   logic               fits_a;
   logic               map_ok_a;
   logic [LEN_W-1:0]   want_a;

   always_comb begin
      req_adj   = (req_bytes_ff < LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : req_bytes_ff;
      round_sum = ROUND_W'(req_adj) + ROUND_W'(SLOT_BYTES - 1);
      slots_a   = round_sum[ROUND_W-1:SLOT_SHIFT];
      need_a    = NEED_W'({slots_a, {SLOT_SHIFT{1'b0}}}) + NEED_W'(SLOT_BYTES);
      pooled_a  = (slots_a <= NCLS_SLOTS);
      cls_a     = CLS_W'(slots_a - SLOTS_W'(1));
      bump_gap  = bump_limit_ff - bump_next_ff;
      map_gap   = heap_limit_ff - map_next_ff;
      fits_a    = (bump_limit_ff >= bump_next_ff) && (NEED_W'(bump_gap) >= need_a);
      map_ok_a  = (map_next_ff <= heap_limit_ff) && (NEED_W'(map_gap) >= need_a)
                  && (map_gap >= REFILL);
      want_a    = (need_a > NEED_W'(REFILL)) ? need_a[LEN_W-1:0] : REFILL;
   end

   logic               zero_ff;
   logic [SLOTS_W-1:0] slots_ff;
   logic               pooled_ff;
   logic [CLS_W-1:0]   cls_ff;
   logic [NEED_W-1:0]  need_ff;
   logic [LEN_W-1:0]   want_ff;
   logic               fits_ff;
   logic               map_ok_ff;

   always_ff @(posedge clock) begin
      if (ctl.look) begin
         zero_ff   <= (req_bytes_ff == '0);
         slots_ff  <= slots_a;
         pooled_ff <= pooled_a;
         cls_ff    <= cls_a;
         need_ff   <= need_a;
         want_ff   <= want_a;
         fits_ff   <= fits_a;
         map_ok_ff <= map_ok_a;
      end
   end

   // Release decode: slot of the header in front of the payload.
   logic [SLOT_W-1:0] off_slots;
   logic [SLOT_W-1:0] rel_slot;
   logic              rel_null;

   assign off_slots = offset_ff[ADDR_W-1:SLOT_SHIFT];
   assign rel_slot  = off_slots - SLOT_W'(1);
   assign rel_null  = (off_slots == '0);

   // Header store: read during decode, written at commit.
   logic [HDR_W-1:0]  header_mem [NUM_SLOTS];
   logic [HDR_W-1:0]  hdr_rd_ff;
   logic              hdr_we;
   logic [SLOT_W-1:0] hdr_wr_addr;

   always_ff @(posedge clock) begin
      if (ctl.look) begin
         hdr_rd_ff <= header_mem[rel_slot];
      end
      if (hdr_we) begin
         header_mem[hdr_wr_addr] <= slots_ff[HDR_W-1:0];
      end
   end

   // Class of a released block, taken from its header.
   logic [CLS_W-1:0] rel_cls;
   logic             rel_leak;

   assign rel_cls  = CLS_W'(hdr_rd_ff - HDR_W'(1));
   assign rel_leak = (hdr_rd_ff == '0) || (hdr_rd_ff > NCLS_HDR);

   logic [CLS_W-1:0] rel_cls_ff;
   logic             rel_leak_ff;

   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         rel_cls_ff  <= rel_cls;
         rel_leak_ff <= rel_leak;
      end
   end

   // Class head store: slot in memory, valid bits in flops cleared by reset.
   logic [SLOT_W-1:0]     head_slot_mem [HEAD_DEPTH];
   logic [HEAD_DEPTH-1:0] head_valid_ff;
   logic [SLOT_W-1:0]     head_rd_ff;
   logic                  head_valid_rd_ff;
   logic                  head_rd_en;
   logic [CLS_W-1:0]      head_rd_addr;
   logic                  head_we;
   logic [CLS_W-1:0]      head_wr_addr;
   logic [SLOT_W-1:0]     head_wr_slot;
   logic                  head_wr_valid;

   assign head_rd_en   = ctl.look || (ctl.fetch && (cmd_ff == CMD_RELEASE));
   assign head_rd_addr = ctl.fetch ? rel_cls : cls_a;

   always_ff @(posedge clock) begin
      if (head_rd_en) begin
         head_rd_ff       <= head_slot_mem[head_rd_addr];
         head_valid_rd_ff <= head_valid_ff[head_rd_addr];
      end
      if (head_we) begin
         head_slot_mem[head_wr_addr] <= head_wr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (head_we) begin
         head_valid_ff[head_wr_addr] <= head_wr_valid;
      end
   end

   // Link store: read at the popped head, written on a push.
   logic [HDR_W-1:0]  next_mem [NUM_SLOTS];
   logic [HDR_W-1:0]  next_rd_ff;
   logic              next_we;

   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         next_rd_ff <= next_mem[head_rd_ff];
      end
      if (next_we) begin
         next_mem[rel_slot] <= {head_valid_rd_ff, head_rd_ff};
      end
   end

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_offset_ff, rsp_offset_in;
   status_code_type       rsp_status_ff, rsp_status_in;

   // Commit: pick the path, update pointers and stores, form the result word.
   logic [LEN_W-1:0] blk;
   logic [LEN_W-1:0] blk_end;

   always_comb begin
      bump_next_in  = bump_next_ff;
      bump_limit_in = bump_limit_ff;
      map_next_in   = map_next_ff;
      hdr_we        = 1'b0;
      hdr_wr_addr   = head_rd_ff;
      head_we       = 1'b0;
      head_wr_addr  = cls_ff;
      head_wr_slot  = next_rd_ff[SLOT_W-1:0];
      head_wr_valid = next_rd_ff[SLOT_W];
      next_we       = 1'b0;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      blk           = fits_ff ? bump_next_ff : map_next_ff;
      blk_end       = blk + need_ff[LEN_W-1:0];

      if (ctl.commit) begin
         rsp_offset_in = '0;
         if (cmd_ff == CMD_ALLOC) begin
            priority if (zero_ff) begin
               rsp_status_in = STS_ZERO;
            end else if (pooled_ff && head_valid_rd_ff) begin
               // Pop the class list head.
               head_we       = 1'b1;
               hdr_we        = 1'b1;
               rsp_offset_in = {head_rd_ff + SLOT_W'(1), {SLOT_SHIFT{1'b0}}};
               rsp_status_in = STS_OK;
            end else if (fits_ff || map_ok_ff) begin
               // Carve from the bump region, refilled from the page source if short.
               if (!fits_ff) begin
                  bump_limit_in = map_next_ff + want_ff;
                  map_next_in   = map_next_ff + want_ff;
               end
               bump_next_in  = blk_end;
               hdr_we        = 1'b1;
               hdr_wr_addr   = blk[ADDR_W-1:SLOT_SHIFT];
               rsp_offset_in = ADDR_W'(blk + LEN_W'(SLOT_BYTES));
               rsp_status_in = STS_OK;
            end else begin
               rsp_status_in = STS_OOM;
            end
         end else begin
            if (rel_null || rel_leak_ff) begin
               rsp_status_in = STS_LEAK;
            end else begin
               // Push the block on its class list.
               next_we       = 1'b1;
               head_we       = 1'b1;
               head_wr_addr  = rel_cls_ff;
               head_wr_slot  = rel_slot;
               head_wr_valid = 1'b1;
               rsp_status_in = STS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_next_ff  <= '0;
         bump_limit_ff <= '0;
         map_next_ff   <= '0;
      end else begin
         bump_next_ff  <= bump_next_in;
         bump_limit_ff <= bump_limit_in;
         map_next_ff   <= map_next_in;
      end
   end

   // The result register takes a new word when empty or being drained.
   assign rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign sts.out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_offset  = rsp_offset_ff;
   assign rsp_status          = rsp_status_ff;

   // The bump pointer never runs past the end of its region.
   a_bump_in_region: assert property (@(posedge clock) disable iff (reset)
      bump_next_ff <= bump_limit_ff)
      else $error("bump pointer passed the region end");

   // The bump region always lies below the page source pointer.
   a_region_mapped: assert property (@(posedge clock) disable iff (reset)
      bump_limit_ff <= map_next_ff)
      else $error("bump region extends past the page source pointer");

   // A new result word appears only after a commit step.
   a_word_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.commit))
      else $error("result word appeared without a commit");

endmodule

// ===== rtl/core/size_class_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list allocator over a heap of byte offsets.
// ----------------------------------------------------------------------------
// Each request word is accepted, then runs through decode with the class head or
// header read, the link or class head read, and commit, which loads the result
// register. A new request is accepted once the previous one has committed, so the
// block takes no new request before it is through with the last one, and commit
// waits while the result register is full and stalled. The chain of dependent
// reads of the class head, header and link stores sets this pace. A finished
// result waits in its own register, so a new request is taken while the previous
// result is stalled. Class list valid bits clear at reset, so no clearing pass is
// needed; the header and link stores hold garbage until written. Configuration
// writes to the heap limit belong in idle periods only.
module size_class_block_allocator #(
   parameter int NUM_CLASSES  = 64,
   parameter int HEAP_BYTES   = 1048576,
   parameter int REFILL_BYTES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [scba_pkg::LEN_W-1:0]   req_request_bytes,
   input  logic [scba_pkg::ADDR_W-1:0]  req_block_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [scba_pkg::ADDR_W-1:0]  rsp_payload_offset,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_write_enable,
   input  logic [scba_pkg::LEN_W-1:0]   csr_write_data
);
   import scba_pkg::*;

   dp_cmd_type    ctl;
   dp_status_type sts;

   // Sequencer.
   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Pointers, stores and result register.
   scba_datapath #(
      .NUM_CLASSES  (NUM_CLASSES),
      .HEAP_BYTES   (HEAP_BYTES),
      .REFILL_BYTES (REFILL_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release words into the size class block allocator,
// tracks its heap state alongside it, and compares every reply word, field
// by field, with the grant worked out for the request, in request order.
// ----------------------------------------------------------------------------
module testbench;
   import scba_pkg::*;

   localparam int NUM_CLASSES  = 64;
   localparam int HEAP_BYTES   = 1048576;
   localparam int REFILL_BYTES = 65536;

   localparam int POOL_CLASSES = (NUM_CLASSES < HEAD_SLOTS) ? NUM_CLASSES : HEAD_SLOTS;
   localparam int POOL_BYTES   = POOL_CLASSES * SLOT_BYTES;

   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TAIL_CYCLES      = 16;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int REPORT_LIMIT     = 10;
   localparam int TABLE_ROWS       = 21;
   localparam int ZERO_LIMIT_ROWS  = 5;
   localparam int RANDOM_WORDS     = 543;
   localparam int PAUSE_AT_WORD    = 270;
   localparam int HOLD_AT_WORD     = 250;
   localparam int FREED_KEEP       = 64;

   localparam logic [LEN_W-1:0] LIMIT_ALL_ONES = {LEN_W{1'b1}};

   // Random phases: sender idle, receiver idle and heap limit of each.
   localparam int SEND_IDLE_PCT [3] = '{16, 66, 0};
   localparam int RECV_IDLE_PCT [3] = '{66, 16, 0};
   localparam logic [LEN_W-1:0] PHASE_LIMIT [3] = '{21'd393216, 21'd0, 21'd1048576};

   typedef struct {
      logic [ADDR_W-1:0] offset;
      status_code_type   status;
   } grant_type;

   typedef struct {
      command_type       cmd;
      logic [LEN_W-1:0]  bytes;
      logic [ADDR_W-1:0] offset;
      bit                typed;
      logic [ADDR_W-1:0] want_offset;
      status_code_type   want_status;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = 1'b0;
   logic [LEN_W-1:0]    req_request_bytes = '0;
   logic [ADDR_W-1:0]   req_block_offset = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ADDR_W-1:0]   rsp_payload_offset;
   logic [1:0]          rsp_status;
   logic                csr_write_enable = 1'b0;
   logic [LEN_W-1:0]    csr_write_data = '0;

   // Heap state mirrored from the requests that the block has taken.
   logic [LEN_W-1:0]    heap_cap = 21'h100000;
   logic [LEN_W-1:0]    bump_ptr = '0;
   logic [LEN_W-1:0]    region_top = '0;
   logic [LEN_W-1:0]    mapped_end = '0;
   logic [HDR_W-1:0]    list_heads [HEAD_SLOTS];
   logic [HDR_W-1:0]    slot_sizes [NUM_SLOTS];
   logic [HDR_W-1:0]    free_links [NUM_SLOTS];

   grant_type           owed_grants [$];
   logic [ADDR_W-1:0]   live_blocks [$];
   logic [ADDR_W-1:0]   freed_blocks [$];
   stim_row_type        opening_rows [TABLE_ROWS];

   int                  fault_count = 0;
   int                  quiet_cycles = 0;
   int                  send_idle_pct = 16;
   int                  recv_idle_pct = 66;
   int                  hold_left = 0;
   bit                  hold_request = 1'b0;
   grant_type           arrived;

   size_class_block_allocator #(
      .NUM_CLASSES  (NUM_CLASSES),
      .HEAP_BYTES   (HEAP_BYTES),
      .REFILL_BYTES (REFILL_BYTES)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   // Works out the grant for one request and advances the mirrored heap.
   task automatic compute_grant(input command_type cmd, input logic [LEN_W-1:0] bytes,
                                input logic [ADDR_W-1:0] off, output grant_type g);
      int unsigned size;
      int unsigned payload;
      int unsigned need;
      int unsigned chunk;
      int unsigned lim;
      int unsigned cls;
      logic [SLOT_W-1:0] slot;
      g.offset = '0;
      g.status = STS_OK;
      if (cmd == CMD_ALLOC) begin
         size = 32'(bytes);
         if (size == 0) begin
            g.status = STS_ZERO;
         end else begin
            if (size < SLOT_BYTES) size = SLOT_BYTES;
            payload = ((size + SLOT_BYTES - 1) >> SLOT_SHIFT) << SLOT_SHIFT;
            cls = (payload >> SLOT_SHIFT) - 1;
            if (payload <= POOL_BYTES && list_heads[cls][HDR_W-1]) begin
               // Pop the head of the class list.
               slot = list_heads[cls][SLOT_W-1:0];
               list_heads[cls] = free_links[slot];
               slot_sizes[slot] = HDR_W'(payload >> SLOT_SHIFT);
               g.offset = ADDR_W'((32'(slot) + 1) << SLOT_SHIFT);
            end else begin
               need = payload + SLOT_BYTES;
               if (region_top < bump_ptr || region_top - bump_ptr < need) begin
                  // Refill the bump region; the old leftover is dropped.
                  chunk = (need > REFILL_BYTES) ? need : REFILL_BYTES;
                  lim = 32'(heap_cap);
                  if (lim > HEAP_BYTES) lim = HEAP_BYTES;
                  if (lim > ADDR_CAP) lim = ADDR_CAP;
                  if (mapped_end > lim || lim - mapped_end < chunk) begin
                     g.status = STS_OOM;
                  end else begin
                     bump_ptr = mapped_end;
                     region_top = LEN_W'(mapped_end + chunk);
                     mapped_end = LEN_W'(mapped_end + chunk);
                  end
               end
               if (g.status == STS_OK) begin
                  slot_sizes[bump_ptr[LEN_W-2:SLOT_SHIFT]] = HDR_W'(payload >> SLOT_SHIFT);
                  g.offset = ADDR_W'(bump_ptr + SLOT_BYTES);
                  bump_ptr = LEN_W'(bump_ptr + need);
               end
            end
         end
      end else begin
         if (off[ADDR_W-1:SLOT_SHIFT] == 0) begin
            g.status = STS_LEAK;
         end else begin
            slot = off[ADDR_W-1:SLOT_SHIFT] - 1'b1;
            payload = 32'(slot_sizes[slot]) << SLOT_SHIFT;
            if (payload == 0 || payload > POOL_BYTES) begin
               g.status = STS_LEAK;
            end else begin
               // Push the block on its class list.
               cls = (payload >> SLOT_SHIFT) - 1;
               free_links[slot] = list_heads[cls];
               list_heads[cls] = {1'b1, slot};
            end
         end
      end
   endtask

   // Offers one word, waits for it to be taken and records its grant.
   task automatic offer_word(input command_type cmd, input logic [LEN_W-1:0] bytes,
                             input logic [ADDR_W-1:0] off, input bit typed,
                             input logic [ADDR_W-1:0] want_offset,
                             input status_code_type want_status);
      grant_type g;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_request_bytes <= bytes;
      req_block_offset <= off;
      do begin
         @(posedge clock);
      end while (req_stall);
      compute_grant(cmd, bytes, off, g);
      if (cmd == CMD_ALLOC && g.status == STS_OK) live_blocks.push_back(g.offset);
      if (typed) begin
         g.offset = want_offset;
         g.status = want_status;
      end
      owed_grants.push_back(g);
      @(negedge clock);
   endtask

   // Holds the sender back until every owed reply has come in.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (owed_grants.size() != 0);
   endtask

   // Writes the heap limit once the block has gone quiet.
   task automatic set_heap_limit(input logic [LEN_W-1:0] value);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      heap_cap = value;
   endtask

   // Mostly allocations of pooled sizes and releases of held blocks, with
   // double releases, null releases and oversized or hopeless sizes mixed in.
   task automatic make_random_word(output command_type cmd, output logic [LEN_W-1:0] bytes,
                                   output logic [ADDR_W-1:0] off);
      int pick;
      int idx;
      pick = $urandom_range(99);
      bytes = LEN_W'($urandom);
      off = ADDR_W'($urandom);
      if (pick < 52) begin
         cmd = CMD_ALLOC;
         pick = $urandom_range(99);
         if (pick < 3) begin
            bytes = '0;
         end else if (pick < 78) begin
            bytes = LEN_W'(16 * $urandom_range(0, 63) + $urandom_range(1, 16));
         end else if (pick < 96) begin
            bytes = LEN_W'($urandom_range(1025, 8192));
         end else if (pick < 99) begin
            bytes = LEN_W'($urandom_range(8193, 200000));
         end
      end else begin
         cmd = CMD_RELEASE;
         pick = $urandom_range(99);
         if (pick < 90 && live_blocks.size() > 0) begin
            idx = $urandom_range(live_blocks.size() - 1);
            off = live_blocks[idx];
            live_blocks.delete(idx);
            freed_blocks.push_back(off);
            if (freed_blocks.size() > FREED_KEEP) void'(freed_blocks.pop_front());
         end else if (pick < 94 && freed_blocks.size() > 0) begin
            off = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
         end else begin
            off = ADDR_W'($urandom_range(0, 15));
         end
         // Now and then the low bits of a real block are set; they are ignored.
         if (off[ADDR_W-1:SLOT_SHIFT] != 0 && $urandom_range(3) == 0) begin
            off[SLOT_SHIFT-1:0] = SLOT_SHIFT'($urandom_range(1, 15));
         end
      end
   endtask

   // Receiver stalls at random, or for one long stretch on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Each reply word taken is compared with the oldest owed grant.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_grants.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= REPORT_LIMIT) begin
               $display("unexpected reply: offset %h status %0d",
                        rsp_payload_offset, rsp_status);
            end
         end else begin
            arrived = owed_grants.pop_front();
            if (rsp_payload_offset !== arrived.offset || rsp_status !== arrived.status) begin
               fault_count = fault_count + 1;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("reply mismatch: offset %h status %0d, wanted offset %h status %0d",
                           rsp_payload_offset, rsp_status, arrived.offset, arrived.status);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither side moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      command_type       cmd;
      logic [LEN_W-1:0]  bytes;
      logic [ADDR_W-1:0] off;

      foreach (list_heads[k]) list_heads[k] = '0;

      // Heap limit of zero for the first rows, all ones from there on.
      opening_rows[0]  = '{CMD_ALLOC,   21'd16,       20'h0,     1'b1, 20'd0,  STS_OOM};
      opening_rows[1]  = '{CMD_ALLOC,   21'd0,        20'hFFFFF, 1'b1, 20'd0,  STS_ZERO};
      opening_rows[2]  = '{CMD_RELEASE, 21'h1FFFFF,   20'd0,     1'b1, 20'd0,  STS_LEAK};
      opening_rows[3]  = '{CMD_RELEASE, 21'd0,        20'd15,    1'b1, 20'd0,  STS_LEAK};
      opening_rows[4]  = '{CMD_ALLOC,   21'h1FFFFF,   20'd0,     1'b1, 20'd0,  STS_OOM};
      opening_rows[5]  = '{CMD_ALLOC,   21'd1,        20'd0,     1'b1, 20'd16, STS_OK};
      opening_rows[6]  = '{CMD_ALLOC,   21'd1024,     20'hAAAAA, 1'b1, 20'd48, STS_OK};
      opening_rows[7]  = '{CMD_ALLOC,   21'd1025,     20'h55555, 1'b0, 20'd0,  STS_OK};
      opening_rows[8]  = '{CMD_ALLOC,   21'h100000,   20'd0,     1'b1, 20'd0,  STS_OOM};
      opening_rows[9]  = '{CMD_RELEASE, 21'd0,        20'd16,    1'b1, 20'd0,  STS_OK};
      opening_rows[10] = '{CMD_ALLOC,   21'd5,        20'd0,     1'b1, 20'd16, STS_OK};
      opening_rows[11] = '{CMD_RELEASE, 21'd0,        20'd57,    1'b1, 20'd0,  STS_OK};
      opening_rows[12] = '{CMD_ALLOC,   21'd1009,     20'd0,     1'b1, 20'd48, STS_OK};
      opening_rows[13] = '{CMD_RELEASE, 21'd0,        20'd1088,  1'b1, 20'd0,  STS_LEAK};
      opening_rows[14] = '{CMD_ALLOC,   21'd200,      20'd0,     1'b0, 20'd0,  STS_OK};
      opening_rows[15] = '{CMD_RELEASE, 21'd0,        20'd2144,  1'b1, 20'd0,  STS_OK};
      opening_rows[16] = '{CMD_RELEASE, 21'd0,        20'd2144,  1'b1, 20'd0,  STS_OK};
      opening_rows[17] = '{CMD_ALLOC,   21'd208,      20'd0,     1'b0, 20'd0,  STS_OK};
      opening_rows[18] = '{CMD_ALLOC,   21'd193,      20'd0,     1'b0, 20'd0,  STS_OK};
      opening_rows[19] = '{CMD_ALLOC,   21'd70000,    20'd0,     1'b0, 20'd0,  STS_OK};
      opening_rows[20] = '{CMD_ALLOC,   21'd1040,     20'd0,     1'b0, 20'd0,  STS_OK};

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed part: special cases and extremes.
      set_heap_limit('0);
      for (int row = 0; row < TABLE_ROWS; row++) begin
         if (row == ZERO_LIMIT_ROWS) set_heap_limit(LIMIT_ALL_ONES);
         offer_word(opening_rows[row].cmd, opening_rows[row].bytes, opening_rows[row].offset,
                    opening_rows[row].typed, opening_rows[row].want_offset,
                    opening_rows[row].want_status);
      end

      // Random phases, each with its own idling and heap limit.
      for (int phase = 0; phase < 3; phase++) begin
         set_heap_limit(PHASE_LIMIT[phase]);
         send_idle_pct = SEND_IDLE_PCT[phase];
         recv_idle_pct = RECV_IDLE_PCT[phase];
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase == 1 && n == PAUSE_AT_WORD) pause_until_drained();
            if (phase == 2 && n == HOLD_AT_WORD) hold_request = 1'b1;
            make_random_word(cmd, bytes, off);
            offer_word(cmd, bytes, off, 1'b0, '0, STS_OK);
         end
      end

      // Let the last replies come in, then give the block time to misbehave.
      pause_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/scba_pkg.sv
rtl/core/scba_ctrl.sv
rtl/core/scba_datapath.sv
rtl/core/size_class_block_allocator.sv
tb/testbench.sv
